// File: design/prb_pkg.sv
// Shared types and constants for the polynomial root bisection unit.
// Holds the fixed-point formats, register indexes and the controller-to-datapath command types.
// Depends on nothing; every other file imports it.
`default_nettype none

package prb_pkg;

    // Fixed-point formats and data widths.
    localparam int X_FRAC_BITS = 28;
    localparam int X_W         = 32;
    localparam int COEFF_W     = 32;
    localparam int TOL_W       = 31;
    localparam int ACC_W       = 33;
    localparam int PROD_W      = ACC_W + X_W;
    localparam int SUM_W       = PROD_W - X_FRAC_BITS + 1;
    localparam int CNT_W       = 6;
    localparam int NUM_COEFF   = 6;
    localparam int CIDX_W      = $clog2(NUM_COEFF);

    // Cap on the number of halvings for one request.
    localparam logic [CNT_W-1:0] MAX_PASSES = CNT_W'(32);

    // Index of the last coefficient in Horner order.
    localparam logic [CIDX_W-1:0] LAST_COEFF = CIDX_W'(NUM_COEFF - 1);

    // Configuration register indexes.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X5 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X4 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_X0 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [COEFF_W-1:0] RST_COEFF_X5 = 32'sd100663296;
    localparam logic [COEFF_W-1:0] RST_COEFF_X4 = -32'sd50331648;
    localparam logic [COEFF_W-1:0] RST_COEFF_X3 = 32'sd16777216;
    localparam logic [COEFF_W-1:0] RST_COEFF_X2 = 32'sd33554432;
    localparam logic [COEFF_W-1:0] RST_COEFF_X1 = -32'sd67108864;
    localparam logic [COEFF_W-1:0] RST_COEFF_X0 = 32'sd83886080;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE = 31'd2684;

    // Coefficients in Horner order: entry 0 is the x^5 term.
    typedef logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff_set_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                    load_in;
        logic                    sel_c;
        logic                    acc_init;
        logic                    mul;
        logic                    add;
        logic [CIDX_W-1:0]       coeff_idx;
        logic                    mid;
        logic                    save_fa;
        logic                    decide;
        logic                    out_load;
        logic [CNT_W-1:0]        halvings;
    } prb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                    converged;
    } prb_status_t;

endpackage

`default_nettype wire

// File: design/polynomial_root_bisection_unit.sv
// Polynomial root bisection unit, top level: configuration registers, controller and datapath.
// Depends on prb_pkg, prb_ctrl and prb_datapath.
//
// Usage: a request on the input channel (in_valid/in_ready) carries left_end and right_end,
// signed Q4.28. The block searches that interval for a root of the fifth-degree polynomial held
// in the coefficient registers (signed Q8.24) and returns one request on the output channel
// (out_valid/out_ready): the last midpoint, the clamped polynomial value there, the number of
// halvings and an exact-zero flag.
// Sequencing: all polynomial evaluations share one multiply-add unit, with a multiply state
// and an add state per Horner step and five steps per evaluation. The value at the left end
// is carried from pass to pass, so later passes evaluate the polynomial only at the midpoint.
// in_ready rises together with out_valid, as the controller returns to idle when the result
// is loaded. One request is in the search at a time.
// The result waits in an output register; a stalled receiver does not hold up the next
// search, which only waits at its end if the previous result is still not taken.
// Reset returns the controller to idle, drops out_valid and loads the register defaults.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while idle; not enforced.
`default_nettype none

module polynomial_root_bisection_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [prb_pkg::REG_IDX_W-1:0]          cfg_index,
    input  wire logic [prb_pkg::COEFF_W-1:0]            cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [prb_pkg::X_W-1:0]         left_end,
    input  wire logic signed [prb_pkg::X_W-1:0]         right_end,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [prb_pkg::X_W-1:0]              root,
    output logic signed [prb_pkg::COEFF_W-1:0]          residual,
    output logic [prb_pkg::CNT_W-1:0]                   halvings,
    output logic                                        exact_zero
);
    import prb_pkg::*;

    coeff_set_t        coeff_set_reg;
    logic [TOL_W-1:0]  tol_reg;
    prb_cmd_t          cmd;
    prb_status_t       status;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_set_reg[0] <= RST_COEFF_X5;
            coeff_set_reg[1] <= RST_COEFF_X4;
            coeff_set_reg[2] <= RST_COEFF_X3;
            coeff_set_reg[3] <= RST_COEFF_X2;
            coeff_set_reg[4] <= RST_COEFF_X1;
            coeff_set_reg[5] <= RST_COEFF_X0;
            tol_reg          <= RST_TOLERANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEFF_X5:  coeff_set_reg[0] <= cfg_data;
                REG_COEFF_X4:  coeff_set_reg[1] <= cfg_data;
                REG_COEFF_X3:  coeff_set_reg[2] <= cfg_data;
                REG_COEFF_X2:  coeff_set_reg[3] <= cfg_data;
                REG_COEFF_X1:  coeff_set_reg[4] <= cfg_data;
                REG_COEFF_X0:  coeff_set_reg[5] <= cfg_data;
                REG_TOLERANCE: tol_reg          <= cfg_data[TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer.
    prb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic and result storage.
    prb_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .left_end   (left_end),
        .right_end  (right_end),
        .coeff_set  (coeff_set_reg),
        .tol        (tol_reg),
        .root       (root),
        .residual   (residual),
        .halvings   (halvings),
        .exact_zero (exact_zero)
    );

endmodule

`default_nettype wire

// File: design/prb_datapath.sv
// Datapath of the root bisection unit: interval ends, midpoint, shared Horner multiply-add
// unit and the result register. Driven by prb_ctrl through command and status structs.
// Depends on prb_pkg.
`default_nettype none

module prb_datapath (
    input  wire logic                                      clk,
    input  wire prb_pkg::prb_cmd_t                         cmd,
    output prb_pkg::prb_status_t                           status,
    input  wire logic signed [prb_pkg::X_W-1:0]            left_end,
    input  wire logic signed [prb_pkg::X_W-1:0]            right_end,
    input  wire prb_pkg::coeff_set_t                       coeff_set,
    input  wire logic [prb_pkg::TOL_W-1:0]                 tol,
    output logic signed [prb_pkg::X_W-1:0]                 root,
    output logic signed [prb_pkg::COEFF_W-1:0]             residual,
    output logic [prb_pkg::CNT_W-1:0]                      halvings,
    output logic                                           exact_zero
);
    import prb_pkg::*;

    localparam logic signed [SUM_W-1:0] ACC_POS = SUM_W'(64'sd4294967295);
    localparam logic signed [SUM_W-1:0] ACC_NEG = -ACC_POS;
    localparam logic signed [ACC_W-1:0] RES_POS = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] RES_NEG = ACC_W'(-64'sd2147483648);

    // Working registers.
    logic signed [X_W-1:0]     a_reg, b_reg, c_reg;
    logic signed [ACC_W-1:0]   fa_reg, acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // Result register.
    logic signed [X_W-1:0]     root_reg;
    logic signed [COEFF_W-1:0] residual_reg;
    logic [CNT_W-1:0]          halvings_reg;
    logic                      exact_zero_reg;

    logic signed [X_W-1:0]     x_op;
    logic signed [X_W:0]       pair_sum;
    logic signed [X_W-1:0]     mid_next;
    logic signed [PROD_W-1:0]  prod_shifted;
    logic signed [SUM_W-1:0]   horner_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic                      opposite;
    logic signed [X_W-1:0]     a_next, b_next;
    logic signed [X_W:0]       width_next;
    logic signed [COEFF_W-1:0] residual_next;

    // Multiplier operand: the left end or the midpoint.
    assign x_op = cmd.sel_c ? c_reg : a_reg;

    // Midpoint, rounded toward minus infinity.
    assign pair_sum = {a_reg[X_W-1], a_reg} + {b_reg[X_W-1], b_reg};
    assign mid_next = pair_sum[X_W:1];

    // Floor shift of the product, add the next coefficient, clamp to the accumulator range.
    assign prod_shifted = prod_reg >>> X_FRAC_BITS;
    assign horner_sum   = prod_shifted[SUM_W-1:0]
                        + SUM_W'($signed(coeff_set[cmd.coeff_idx]));

    always_comb
    begin
        if (horner_sum > ACC_POS)
        begin
            acc_sat = ACC_POS[ACC_W-1:0];
        end
        else if (horner_sum < ACC_NEG)
        begin
            acc_sat = ACC_NEG[ACC_W-1:0];
        end
        else
        begin
            acc_sat = horner_sum[ACC_W-1:0];
        end
    end

    // Bracket update: keep the left half if its ends differ strictly in sign, else the right half.
    assign opposite = ((fa_reg < 0) && (acc_reg > 0)) || ((fa_reg > 0) && (acc_reg < 0));
    assign a_next   = opposite ? a_reg : c_reg;
    assign b_next   = opposite ? c_reg : b_reg;
    assign width_next = {b_next[X_W-1], b_next} - {a_next[X_W-1], a_next};

    assign status.converged = (acc_reg == '0)
                            || (width_next <= $signed({2'b00, tol}));

    // Residual clamped to the signed 32-bit range.
    always_comb
    begin
        if (acc_reg > RES_POS)
        begin
            residual_next = RES_POS[COEFF_W-1:0];
        end
        else if (acc_reg < RES_NEG)
        begin
            residual_next = RES_NEG[COEFF_W-1:0];
        end
        else
        begin
            residual_next = acc_reg[COEFF_W-1:0];
        end
    end

    // Interval and function-value registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= left_end;
            b_reg <= right_end;
        end
        else if (cmd.decide)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.mid)
        begin
            c_reg <= mid_next;
        end
        if (cmd.save_fa)
        begin
            fa_reg <= acc_reg;
        end
        else if (cmd.decide && !opposite)
        begin
            fa_reg <= acc_reg;
        end
    end

    // Shared Horner unit: a registered multiply, then a registered add and clamp.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= acc_reg * x_op;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= ACC_W'($signed(coeff_set[0]));
        end
        else if (cmd.add)
        begin
            acc_reg <= acc_sat;
        end
    end

    // Result register, loaded once the output side is free.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            root_reg       <= c_reg;
            residual_reg   <= residual_next;
            halvings_reg   <= cmd.halvings;
            exact_zero_reg <= (acc_reg == '0);
        end
    end

    assign root       = root_reg;
    assign residual   = residual_reg;
    assign halvings   = halvings_reg;
    assign exact_zero = exact_zero_reg;

endmodule

`default_nettype wire

// File: design/prb_ctrl.sv
// Controller of the root bisection unit: request handshake, the pass and coefficient
// sequencing of the Horner unit, and the output valid flag.
// Depends on prb_pkg.
`default_nettype none

module prb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output prb_pkg::prb_cmd_t          cmd,
    input  wire prb_pkg::prb_status_t  status
);
    import prb_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INIT   = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_ADD    = 7'b0001000,
        ST_MID    = 7'b0010000,
        ST_DECIDE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CIDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  pass_cnt_reg, pass_cnt_next;
    logic              eval_a_reg, eval_a_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              stop;

    assign out_free  = !out_valid_reg || out_ready;
    assign stop      = status.converged || (pass_cnt_reg >= MAX_PASSES);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        pass_cnt_next = pass_cnt_reg;
        eval_a_next   = eval_a_reg;
        cmd           = '0;
        cmd.sel_c     = !eval_a_reg;
        cmd.coeff_idx = k_reg;
        cmd.halvings  = pass_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    eval_a_next   = 1'b1;
                    pass_cnt_next = '0;
                    state_next    = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.acc_init = 1'b1;
                k_next       = CIDX_W'(1);
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (k_reg != LAST_COEFF)
                begin
                    k_next     = k_reg + CIDX_W'(1);
                    state_next = ST_MUL;
                end
                else if (eval_a_reg)
                begin
                    state_next = ST_MID;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_MID:
            begin
                cmd.mid       = 1'b1;
                cmd.save_fa   = eval_a_reg;
                eval_a_next   = 1'b0;
                pass_cnt_next = pass_cnt_reg + CNT_W'(1);
                state_next    = ST_INIT;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stop ? ST_FINISH : ST_MID;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a result load, cleared once the request is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pass_cnt_reg  <= '0;
            eval_a_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pass_cnt_reg  <= pass_cnt_next;
            eval_a_reg    <= eval_a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The pass count never runs past the cap.
    a_pass_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pass_cnt_reg <= MAX_PASSES)
        else $error("pass count exceeds cap");

    // A result is loaded only when the output register is free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result overwrote a pending output");

    // An accepted request starts with the evaluation at the left end.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_INIT) && eval_a_reg)
        else $error("request did not start an evaluation");

    // At the cap the search always finishes.
    a_cap_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) && (pass_cnt_reg == MAX_PASSES) |=> state_reg == ST_FINISH)
        else $error("search ran past the pass cap");

endmodule

`default_nettype wire
